FILE: sv/urm_pkg.sv
// Shared types and codes for the unbiased random modulo core.
`timescale 1ns / 1ps

package urm_pkg;

    // Beat kinds on the request channel
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_BYTE    = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    // Width of the bytes-gathered counter
    localparam int CNT_BITS = 4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       take_req;   // latch modulus and size, drop any pending work
        logic       take_byte;  // pack one entropy byte
        logic       div_start;  // launch the remainder unit
        logic       div_sel;    // 0: limit from request beat, 1: held word by held modulus
        logic       set_limit;  // store limit and mark the request pending
        logic       clear_word; // drop a rejected word
        logic       finish;     // close the request
        logic       emit;       // load the output register
        logic [1:0] emit_code;  // status to emit
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic req_zero;  // request beat carries a zero modulus
        logic req_over;  // request beat carries a modulus above the word maximum
        logic pending;   // a request waits for bytes
        logic word_full; // this byte completes the word
        logic reject;    // held word is at or above the limit
        logic div_done;  // remainder is ready
        logic out_free;  // output register can take a beat
    } t_sts;

endpackage

FILE: sv/urm_if.sv
// Valid/ready channel interfaces for request beats and result beats.
`timescale 1ns / 1ps

interface urm_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] modulus;
    logic [1:0]  word_size;
    logic [7:0]  random_byte;

    modport source (output valid, action, modulus, word_size, random_byte, input ready);
    modport sink   (input valid, action, modulus, word_size, random_byte, output ready);
endinterface

interface urm_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

FILE: sv/urm_rem.sv
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module urm_rem #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic [W-1:0] o_rem,
    output logic         o_done
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_dvd;
    logic [W-1:0]  r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[W-1:0];
        end else begin
            n_rem = w_trial[W-1:0];
        end
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[W-2:0], 1'b0};
        end
    end

    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

FILE: sv/urm_datapath.sv
// Request state, byte packing, limit compare, remainder unit and result register.
`timescale 1ns / 1ps

module urm_datapath
    import urm_pkg::*;
#(
    parameter int W = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [63:0] i_modulus,
    input  logic [1:0]  i_word_size,
    input  logic [7:0]  i_random_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_value,
    output logic [1:0]  o_status
);

    // Sample width in bits, saturated to the datapath width
    function automatic int f_bits(input logic [1:0] sel);
        int b;
        b = 8 << sel;
        if (b > W) begin
            b = W;
        end
        return b;
    endfunction

    // All-ones value of the sample width
    function automatic logic [W-1:0] f_top(input logic [1:0] sel);
        logic [W-1:0] ones;
        ones = '1;
        return ones >> (W - f_bits(sel));
    endfunction

    // Bytes that make one word
    function automatic logic [CNT_BITS-1:0] f_need(input logic [1:0] sel);
        int b;
        b = f_bits(sel) + 7;
        return CNT_BITS'(b >> 3);
    endfunction

    logic [W-1:0]        r_mod;
    logic [1:0]          r_size;
    logic [CNT_BITS-1:0] r_cnt;
    logic [W-1:0]        r_sample;
    logic [W-1:0]        r_limit;
    logic                r_pending;
    logic                r_valid;
    logic [63:0]         r_value;
    logic [1:0]          r_status;
    logic [W-1:0]        w_top_in;
    logic [W-1:0]        w_top_held;
    logic [W+7:0]        w_shifted;
    logic [W-1:0]        n_sample;
    logic [CNT_BITS-1:0] n_cnt;
    logic [W-1:0]        w_dividend;
    logic [W-1:0]        w_divisor;
    logic [W-1:0]        w_rem;
    logic                w_done;

    assign w_top_in   = f_top(i_word_size);
    assign w_top_held = f_top(r_size);
    assign w_shifted  = {r_sample, i_random_byte};
    assign n_sample   = w_shifted[W-1:0] & w_top_held;
    assign n_cnt      = r_cnt + CNT_BITS'(1);

    // Pick remainder operands: limit from the request beat, or the held word
    assign w_dividend = i_cmd.div_sel ? r_sample : w_top_in;
    assign w_divisor  = i_cmd.div_sel ? r_mod : i_modulus[W-1:0];

    urm_rem #(
        .W (W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_rem      (w_rem),
        .o_done     (w_done)
    );

    // Track the pending request and the gathered byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_cmd.take_req || i_cmd.finish) begin
                r_pending <= 1'b0;
            end else if (i_cmd.set_limit) begin
                r_pending <= 1'b1;
            end
            if (i_cmd.take_req) begin
                r_cnt <= '0;
            end else if (i_cmd.take_byte) begin
                r_cnt <= (n_cnt == f_need(r_size)) ? '0 : n_cnt;
            end
        end
    end

    // Hold request operands, the word being gathered and the limit
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_mod  <= i_modulus[W-1:0];
            r_size <= i_word_size;
        end
        if (i_cmd.take_req || i_cmd.clear_word || i_cmd.finish) begin
            r_sample <= '0;
        end else if (i_cmd.take_byte) begin
            r_sample <= n_sample;
        end
        if (i_cmd.set_limit) begin
            r_limit <= w_top_held - w_rem;
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_value  <= (i_cmd.emit_code == ST_OK) ? 64'(w_rem) : 64'd0;
            r_status <= i_cmd.emit_code;
        end
    end

    always_comb begin
        o_sts.req_zero  = (i_modulus == 64'd0);
        o_sts.req_over  = (i_modulus > 64'(w_top_in));
        o_sts.pending   = r_pending;
        o_sts.word_full = (n_cnt == f_need(r_size));
        o_sts.reject    = (r_sample >= r_limit);
        o_sts.div_done  = w_done;
        o_sts.out_free  = !r_valid || i_ready;
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

FILE: sv/urm_ctrl.sv
// Sequencer for request setup, byte gathering, limit check and result emit.
`timescale 1ns / 1ps

module urm_ctrl
    import urm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_action,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LIMIT = 5'b00010,
        S_CHECK = 5'b00100,
        S_REM   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_code, n_code;
    logic       w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.emit_code = r_code;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_action == ACT_REQUEST)) begin
                    o_cmd.take_req = 1'b1;
                    if (i_sts.req_zero) begin
                        n_code  = ST_ZERO;
                        n_state = S_EMIT;
                    end else if (i_sts.req_over) begin
                        n_code  = ST_OVER;
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_LIMIT;
                    end
                end else if (w_accept && i_sts.pending) begin
                    o_cmd.take_byte = 1'b1;
                    if (i_sts.word_full) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_LIMIT: begin
                if (i_sts.div_done) begin
                    o_cmd.set_limit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_sts.reject) begin
                    o_cmd.clear_word = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 1'b1;
                    n_state = S_REM;
                end
            end
            S_REM: begin
                if (i_sts.div_done) begin
                    o_cmd.finish = 1'b1;
                    n_code  = ST_OK;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

FILE: sv/unbiased_random_modulo_core.sv
// Word path: last byte, limit check, remainder unit, emit step, result register.
// Request beat: the remainder unit finds the limit, then beats resume; errors emit.
// Beats are taken one at a time, only while idle; the remainder unit sets the pace.
// Reset: synchronous active low; clears the pending request, sequencer and result valid.
// No clearing pass; the block takes beats as soon as reset is released.
`timescale 1ns / 1ps

module unbiased_random_modulo_core
    import urm_pkg::*;
#(
    parameter int MAX_WORD_BITS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    urm_req_if.sink      i_req,
    urm_res_if.source    o_res
);

    t_cmd s_cmd;
    t_sts s_sts;

    urm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .i_action (i_req.action),
        .o_ready  (i_req.ready),
        .i_sts    (s_sts),
        .o_cmd    (s_cmd)
    );

    urm_datapath #(
        .W (MAX_WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_sts         (s_sts),
        .i_modulus     (i_req.modulus),
        .i_word_size   (i_req.word_size),
        .i_random_byte (i_req.random_byte),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_value       (o_res.value),
        .o_status      (o_res.status)
    );

`ifndef SYNTHESIS
    // Error beats carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.status != ST_OK) |-> (o_res.value == 64'd0))
        else $error("error result with nonzero value");

    // No beat is taken while a remainder completes
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_sts.div_done |-> !i_req.ready)
        else $error("request channel ready during remainder completion");

    // A result only appears out of the emit step
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit |-> !i_req.ready)
        else $error("result loaded while accepting beats");
`endif

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the unbiased random modulo core.
`timescale 1ns / 1ps

module testbench;
    import urm_pkg::*;

    localparam int WORD_CAP     = 64;
    localparam int TOTAL_BEATS  = 1850;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD    = 500;
    localparam int HOLD_AT      = 40;
    localparam int CALM_TAIL    = 200;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic        act;
        logic [63:0] modulus;
        logic [1:0]  size;
        logic [7:0]  rbyte;
        bit          drain_first;
    } t_beat;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    urm_req_if req_ch();
    urm_res_if res_ch();

    unbiased_random_modulo_core #(
        .MAX_WORD_BITS(WORD_CAP)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Stimulus and expected results
    t_beat   beat_queue[$];
    t_result due_results[$];
    t_beat   cur_beat;
    bit      drain_next;
    int      total_beats;

    // Shadow of the sampler state
    logic [63:0] held_n;
    logic [1:0]  held_sel;
    logic [3:0]  byte_count;
    logic [63:0] gathered;
    logic [63:0] reject_bound;
    logic        armed;

    // Bookkeeping
    int results_predicted;
    int results_seen;
    int beats_accepted;
    int fail_count;
    int n_requests, n_bytes, n_ignored, n_rejected;
    int n_ok, n_zero, n_over;
    int send_gap, send_idle_pct;
    int recv_gap, recv_idle_pct;
    int hold_left;
    bit hold_done;
    logic hold_off;
    logic calm;
    int cycle_count;
    t_result want;

    function automatic int unsigned word_bits(input logic [1:0] sel);
        int unsigned bits;
        int unsigned cap;
        bits = 8 << sel;
        cap  = WORD_CAP;
        if (cap < 8) cap = 8;
        if (cap > 64) cap = 64;
        return (bits > cap) ? cap : bits;
    endfunction

    function automatic logic [63:0] word_max(input int unsigned bits);
        if (bits >= 64) return '1;
        return (64'd1 << bits) - 64'd1;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("MISMATCH: %s", msg);
    endtask

    task automatic expect_result(input logic [63:0] value, input logic [1:0] status);
        t_result r;
        r.value  = value;
        r.status = status;
        due_results.push_back(r);
        results_predicted++;
    endtask

    // Advance the shadow sampler by one accepted beat
    task automatic compute_sample_result(input t_beat b);
        int unsigned bits;
        int unsigned need;
        logic [63:0] top;
        if (b.act == ACT_REQUEST) begin
            n_requests++;
            top        = word_max(word_bits(b.size));
            armed      = 1'b0;
            byte_count = '0;
            gathered   = '0;
            if (b.modulus == 64'd0) begin
                expect_result(64'd0, ST_ZERO);
            end else if (b.modulus > top) begin
                expect_result(64'd0, ST_OVER);
            end else begin
                held_n       = b.modulus;
                held_sel     = b.size;
                reject_bound = top - (top % b.modulus);
                armed        = 1'b1;
            end
        end else begin
            n_bytes++;
            if (!armed) begin
                n_ignored++;
            end else begin
                bits       = word_bits(held_sel);
                top        = word_max(bits);
                need       = (bits + 7) / 8;
                gathered   = ((gathered << 8) | {56'd0, b.rbyte}) & top;
                byte_count = byte_count + 4'd1;
                if (byte_count >= need) begin
                    byte_count = '0;
                    if (gathered >= reject_bound || held_n == 64'd0) begin
                        n_rejected++;
                    end else begin
                        expect_result(gathered % held_n, ST_OK);
                        armed = 1'b0;
                    end
                    gathered = '0;
                end
            end
        end
    endtask

    // Queue one beat; unused fields carry random content
    task automatic push_beat(input logic act, input logic [63:0] n, input logic [1:0] sel,
                             input logic [7:0] b);
        t_beat nb;
        nb.act         = act;
        nb.modulus     = (act == ACT_REQUEST) ? n : rand64();
        nb.size        = (act == ACT_REQUEST) ? sel : 2'($urandom);
        nb.rbyte       = (act == ACT_BYTE) ? b : 8'($urandom);
        nb.drain_first = drain_next;
        drain_next     = 1'b0;
        beat_queue.push_back(nb);
    endtask

    // Queue the bytes of one word, most significant first
    task automatic push_word(input logic [1:0] sel, input logic [63:0] w);
        int need;
        need = (word_bits(sel) + 7) / 8;
        for (int i = need - 1; i >= 0; i--) push_beat(ACT_BYTE, '0, '0, w[i*8 +: 8]);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: offer queued beats, hold on backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid       <= 1'b0;
            req_ch.action      <= ACT_REQUEST;
            req_ch.modulus     <= '0;
            req_ch.word_size   <= '0;
            req_ch.random_byte <= '0;
            send_gap           = 0;
            send_idle_pct      = 10;
            beats_accepted     <= 0;
            calm               <= 1'b0;
            held_n             = '0;
            held_sel           = '0;
            byte_count         = '0;
            gathered           = '0;
            reject_bound       = '0;
            armed              = 1'b0;
        end else begin
            calm <= (beat_queue.size() < CALM_TAIL);
            if (req_ch.valid && req_ch.ready) begin
                compute_sample_result(cur_beat);
                beats_accepted <= beats_accepted + 1;
                if ((beats_accepted + 1) % 150 == 0) begin
                    case ($urandom_range(0, 2))
                        0: send_idle_pct = 0;
                        1: send_idle_pct = 10;
                        default: send_idle_pct = 35;
                    endcase
                end
                if (!calm && send_gap == 0 && $urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(1, 6);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (beat_queue.size() != 0 &&
                             !(beat_queue[0].drain_first &&
                               results_predicted != results_seen)) begin
                    cur_beat = beat_queue.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.action      <= cur_beat.act;
                    req_ch.modulus     <= cur_beat.modulus;
                    req_ch.word_size   <= cur_beat.size;
                    req_ch.random_byte <= cur_beat.rbyte;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready  <= 1'b0;
            results_seen  <= 0;
            recv_gap      = 0;
            recv_idle_pct = 5;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen <= results_seen + 1;
                if (due_results.size() == 0) begin
                    note_failure($sformatf("unexpected result value=%h status=%0d",
                                           res_ch.value, res_ch.status));
                end else begin
                    want = due_results.pop_front();
                    if (res_ch.value !== want.value || res_ch.status !== want.status)
                        note_failure($sformatf(
                            "result %0d: expected value=%h status=%0d, got value=%h status=%0d",
                            results_seen, want.value, want.status, res_ch.value, res_ch.status));
                    case (want.status)
                        ST_OK:   n_ok++;
                        ST_ZERO: n_zero++;
                        default: n_over++;
                    endcase
                end
            end
            if (cycle_count % 300 == 0) begin
                case ($urandom_range(0, 2))
                    0: recv_idle_pct = 0;
                    1: recv_idle_pct = 5;
                    default: recv_idle_pct = 15;
                endcase
            end
            if (recv_gap == 0 && !calm && $urandom_range(0, 99) < recv_idle_pct)
                recv_gap = $urandom_range(1, 6);
            if (recv_gap != 0) begin
                recv_gap--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= !hold_off;
            end
        end
    end

    // Hold the result side off once for a long stretch so the core backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off  <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else if (!hold_done && results_seen == HOLD_AT) begin
            hold_off  <= 1'b1;
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
            if (hold_left == 0) hold_off <= 1'b0;
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Build the stimulus, run reset, wait for the drain and report
    initial begin
        int          kind;
        logic [1:0]  sel;
        logic [63:0] top;
        logic [63:0] n;
        logic [63:0] bound;
        logic [63:0] w;
        int          need;
        int          bits;
        int          next_mark;
        int          missing;

        i_rst_n     = 1'b0;
        drain_next  = 1'b0;

        // Directed: byte while idle, both error codes, edge moduli, rejects, replacement
        push_beat(ACT_BYTE, '0, '0, 8'hA5);
        push_beat(ACT_REQUEST, 64'd0, 2'd0, '0);
        push_beat(ACT_REQUEST, 64'd0, 2'd3, '0);
        push_beat(ACT_REQUEST, 64'd256, 2'd0, '0);
        push_beat(ACT_REQUEST, 64'h1_0000, 2'd1, '0);
        push_beat(ACT_REQUEST, 64'hFFFF_FFFF_FFFF_FFFF, 2'd2, '0);
        push_beat(ACT_REQUEST, 64'd200, 2'd0, '0);
        push_beat(ACT_BYTE, '0, '0, 8'hFF);
        push_beat(ACT_BYTE, '0, '0, 8'h05);
        push_beat(ACT_REQUEST, 64'd255, 2'd0, '0);
        push_beat(ACT_BYTE, '0, '0, 8'hFF);
        push_beat(ACT_BYTE, '0, '0, 8'h00);
        push_beat(ACT_REQUEST, 64'd1, 2'd1, '0);
        push_word(2'd1, 64'h1234);
        push_beat(ACT_REQUEST, 64'd7, 2'd2, '0);
        push_beat(ACT_BYTE, '0, '0, 8'h01);
        push_beat(ACT_REQUEST, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, '0);
        push_word(2'd3, 64'hFFFF_FFFF_FFFF_FFFE);

        // Random: mostly complete requests, some broken ones, errors and stray bytes
        drain_next = 1'b1;
        next_mark  = beat_queue.size() + 450;
        while (beat_queue.size() < TOTAL_BEATS) begin
            if (beat_queue.size() >= next_mark) begin
                drain_next = 1'b1;
                next_mark += 450;
            end
            kind = $urandom_range(0, 99);
            sel  = 2'($urandom);
            bits = word_bits(sel);
            top  = word_max(bits);
            need = (bits + 7) / 8;
            if (kind < 80) begin
                case ($urandom_range(0, 4))
                    0: n = $urandom_range(1, 20);
                    1: n = rand64() & top;
                    2: n = (top >> 1) + 64'd1 + $urandom_range(0, 3);
                    3: n = top - $urandom_range(0, 2);
                    default: n = 64'd1 << $urandom_range(0, bits - 1);
                endcase
                if (n == 64'd0) n = 64'd1;
                bound = top - (top % n);
                push_beat(ACT_REQUEST, n, sel, '0);
                if (kind < 70) begin
                    // Force a rejected word now and then, then draw up to six words until one passes
                    if ($urandom_range(0, 2) == 0)
                        push_word(sel, bound + (rand64() % (top - bound + 64'd1)));
                    for (int t = 0; t < 6; t++) begin
                        w = rand64() & top;
                        push_word(sel, w);
                        if (w < bound) break;
                    end
                end else if (need > 1) begin
                    // Broken: leave the word unfinished
                    for (int k = $urandom_range(1, need - 1); k > 0; k--)
                        push_beat(ACT_BYTE, '0, '0, 8'($urandom));
                end
            end else if (kind < 88) begin
                if (sel == 2'd3 || $urandom_range(0, 1) == 0)
                    push_beat(ACT_REQUEST, 64'd0, sel, '0);
                else
                    push_beat(ACT_REQUEST, rand64() | (top + 64'd1), sel, '0);
            end else begin
                for (int k = $urandom_range(1, 3); k > 0; k--)
                    push_beat(ACT_BYTE, '0, '0, 8'($urandom));
            end
        end
        total_beats = beat_queue.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_accepted != total_beats) @(posedge i_clk);
        while (results_seen != results_predicted) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        missing = due_results.size();
        if (missing != 0)
            $display("MISMATCH: %0d expected results never arrived", missing);

        $display("Sent %0d beats: %0d requests, %0d entropy bytes (%0d while idle),",
                 beats_accepted, n_requests, n_bytes, n_ignored);
        $display("%0d rejected words; checked %0d results: %0d ok, %0d zero, %0d too large",
                 n_rejected, results_seen, n_ok, n_zero, n_over);
        if (fail_count == 0 && missing == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
